@@ rtl/stb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the source byte tokenizer
// Token kinds, character codes, default widths and small helpers used by
// the scanner front end, the token queue and the output back end.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int unsigned OFFSET_BITS_DEF   = 24;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH_DEF    = 4;

  // tokens per queue entry: one input byte yields at most this many
  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned CNT_BITS   = 2;
  localparam int unsigned KIND_BITS  = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_IDENT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_STRING = 3'd2,
    KIND_SYMBOL = 3'd3,
    KIND_EOF    = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic int unsigned token_bits(input int unsigned ob, input int unsigned pb);
    return KIND_BITS + 2 * ob + 2 * pb;
  endfunction

  function automatic int unsigned bundle_bits(input int unsigned ob, input int unsigned pb);
    return CNT_BITS + MAX_TOKENS * token_bits(ob, pb);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage
`default_nettype wire

@@ rtl/stb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_front: scanner front end
// Takes one source byte per beat, updates the scan mode and position
// counters, and pushes the tokens that byte closes as one queue entry.
// ----------------------------------------------------------------------------
module stb_front #(
  parameter int unsigned OFFSET_BITS   = stb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [7:0]             source_byte_i,
  input  wire logic                   end_of_source_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire stb_pkg::fifo_status_t  fifo_status_i,
  output logic                        push_o,
  output logic [stb_pkg::bundle_bits(OFFSET_BITS, POSITION_BITS)-1:0] push_data_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_DOLLAR = 3'd4;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0]   OFF_ONE = OFFSET_BITS'(1);

  typedef struct packed {
    stb_pkg::kind_e             kind;
    logic [OFFSET_BITS-1:0]     off;
    logic [OFFSET_BITS-1:0]     len;
    logic [POSITION_BITS-1:0]   row;
    logic [POSITION_BITS-1:0]   col;
  } tok_t;

  typedef struct packed {
    logic [stb_pkg::CNT_BITS-1:0]   cnt;
    tok_t [stb_pkg::MAX_TOKENS-1:0] tok;
  } bundle_t;

  logic [2:0]               mode_q, mode_d;
  logic [OFFSET_BITS-1:0]   beg_off_q, beg_off_d;
  logic [POSITION_BITS-1:0] beg_row_q, beg_row_d;
  logic [POSITION_BITS-1:0] beg_col_q, beg_col_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d;
  logic [POSITION_BITS-1:0] row_q, row_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  bundle_t                  bundle;
  logic                     accept;

  function automatic tok_t make_tok(input stb_pkg::kind_e k, input logic [OFFSET_BITS-1:0] o,
                                    input logic [OFFSET_BITS-1:0] l,
                                    input logic [POSITION_BITS-1:0] r,
                                    input logic [POSITION_BITS-1:0] c);
    tok_t t;
    t.kind = k;
    t.off  = o;
    t.len  = l;
    t.row  = r;
    t.col  = c;
    return t;
  endfunction

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic       consumed;
    logic       letter;
    logic       digit;
    logic [1:0] n;
    logic [7:0] b;
    b         = source_byte_i;
    letter    = stb_pkg::is_letter(b);
    digit     = stb_pkg::is_digit(b);
    consumed  = 1'b0;
    n         = 2'd0;
    bundle    = '0;
    mode_d    = mode_q;
    beg_off_d = beg_off_q;
    beg_row_d = beg_row_q;
    beg_col_d = beg_col_q;

    // close or extend the open token
    unique case (mode_q)
      MODE_IDENT: begin
        if (letter || digit) begin
          consumed = 1'b1;
        end else begin
          bundle.tok[n] = make_tok(stb_pkg::KIND_IDENT, beg_off_q, off_q - beg_off_q,
                                   beg_row_q, beg_col_q);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit) begin
          consumed = 1'b1;
        end else begin
          bundle.tok[n] = make_tok(stb_pkg::KIND_NUMBER, beg_off_q, off_q - beg_off_q,
                                   beg_row_q, beg_col_q);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        consumed = 1'b1;
        if (b == stb_pkg::CH_QUOTE) begin
          bundle.tok[n] = make_tok(stb_pkg::KIND_STRING, beg_off_q,
                                   off_q + OFF_ONE - beg_off_q, beg_row_q, beg_col_q);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_DOLLAR: begin
        if (letter) begin
          consumed = 1'b1;
          mode_d   = MODE_IDENT;
        end else begin
          bundle.tok[n] = make_tok(stb_pkg::KIND_SYMBOL, beg_off_q, OFF_ONE,
                                   beg_row_q, beg_col_q);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    // start a new token, or emit a one-byte symbol, on a byte the open token did not take
    if (!consumed) begin
      if (b == stb_pkg::CH_NL || b == stb_pkg::CH_SPACE || b == stb_pkg::CH_TAB ||
          b == stb_pkg::CH_CR) begin
        // whitespace: skip
      end else if (b == stb_pkg::CH_DOLLAR || letter || digit || b == stb_pkg::CH_QUOTE) begin
        if (b == stb_pkg::CH_DOLLAR) mode_d = MODE_DOLLAR;
        else if (letter)             mode_d = MODE_IDENT;
        else if (digit)              mode_d = MODE_NUMBER;
        else                         mode_d = MODE_STRING;
        beg_off_d = off_q;
        beg_row_d = row_q;
        beg_col_d = col_q;
      end else begin
        bundle.tok[n] = make_tok(stb_pkg::KIND_SYMBOL, off_q, OFF_ONE, row_q, col_q);
        n = n + 2'd1;
      end
    end

    off_d = off_q + OFF_ONE;
    if (b == stb_pkg::CH_NL) begin
      row_d = (row_q != POS_MAX) ? row_q + POS_ONE : row_q;
      col_d = POS_ONE;
    end else begin
      row_d = row_q;
      col_d = (col_q != POS_MAX) ? col_q + POS_ONE : col_q;
    end

    // last byte: flush open token, add end marker (open string: error token only), reset
    if (end_of_source_i) begin
      if (mode_d == MODE_STRING) begin
        bundle.tok[n] = make_tok(stb_pkg::KIND_ERROR, beg_off_d, off_d - beg_off_d,
                                 beg_row_d, beg_col_d);
        n = n + 2'd1;
      end else begin
        if (mode_d == MODE_IDENT || mode_d == MODE_NUMBER) begin
          bundle.tok[n] = make_tok((mode_d == MODE_IDENT) ? stb_pkg::KIND_IDENT
                                                          : stb_pkg::KIND_NUMBER,
                                   beg_off_d, off_d - beg_off_d, beg_row_d, beg_col_d);
          n = n + 2'd1;
        end else if (mode_d == MODE_DOLLAR) begin
          bundle.tok[n] = make_tok(stb_pkg::KIND_SYMBOL, beg_off_d, OFF_ONE,
                                   beg_row_d, beg_col_d);
          n = n + 2'd1;
        end
        bundle.tok[n] = make_tok(stb_pkg::KIND_EOF, off_d, '0, row_d, col_d);
        n = n + 2'd1;
      end
      mode_d    = MODE_IDLE;
      beg_off_d = '0;
      beg_row_d = POS_ONE;
      beg_col_d = POS_ONE;
      off_d     = '0;
      row_d     = POS_ONE;
      col_d     = POS_ONE;
    end

    bundle.cnt = n;
  end

  assign push_o      = accept && (bundle.cnt != '0);
  assign push_data_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      beg_off_q <= '0;
      beg_row_q <= POS_ONE;
      beg_col_q <= POS_ONE;
      off_q     <= '0;
      row_q     <= POS_ONE;
      col_q     <= POS_ONE;
    end else if (accept) begin
      mode_q    <= mode_d;
      beg_off_q <= beg_off_d;
      beg_row_q <= beg_row_d;
      beg_col_q <= beg_col_d;
      off_q     <= off_d;
      row_q     <= row_d;
      col_q     <= col_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/stb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_fifo: token queue
// Short first-in first-out queue of token groups between the scanner and
// the output stage; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module stb_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = stb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [DATA_W-1:0]     push_data_i,
  input  wire logic                  pop_i,
  output logic [DATA_W-1:0]          head_data_o,
  output stb_pkg::fifo_status_t      status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_data_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/stb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_back: token output stage
// Walks the tokens of the queue head one per beat into the output register
// and pops the entry with its last token, which carries last_of_run.
// ----------------------------------------------------------------------------
module stb_back #(
  parameter int unsigned OFFSET_BITS   = stb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [stb_pkg::bundle_bits(OFFSET_BITS, POSITION_BITS)-1:0] head_data_i,
  input  wire stb_pkg::fifo_status_t  fifo_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  token_kind_o,
  output logic [OFFSET_BITS-1:0]      start_offset_o,
  output logic [OFFSET_BITS-1:0]      token_length_o,
  output logic [POSITION_BITS-1:0]    start_row_o,
  output logic [POSITION_BITS-1:0]    start_col_o,
  output logic                        last_of_run_o
);

  typedef struct packed {
    stb_pkg::kind_e             kind;
    logic [OFFSET_BITS-1:0]     off;
    logic [OFFSET_BITS-1:0]     len;
    logic [POSITION_BITS-1:0]   row;
    logic [POSITION_BITS-1:0]   col;
  } tok_t;

  typedef struct packed {
    logic [stb_pkg::CNT_BITS-1:0]   cnt;
    tok_t [stb_pkg::MAX_TOKENS-1:0] tok;
  } bundle_t;

  bundle_t                      head;
  tok_t                         sel;
  logic [stb_pkg::CNT_BITS-1:0] idx_q, idx_d;
  logic                         valid_q, valid_d;
  logic                         load;
  logic                         last_tok;
  tok_t                         tok_q;
  logic                         last_q;

  assign head     = bundle_t'(head_data_i);
  assign sel      = head.tok[idx_q];
  assign last_tok = (idx_q == head.cnt - stb_pkg::CNT_BITS'(1));
  assign load     = !fifo_status_i.empty && (!valid_q || !out_stall_i);
  assign pop_o    = load && last_tok;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_tok ? '0 : idx_q + stb_pkg::CNT_BITS'(1);
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= sel;
      last_q <= last_tok;
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = tok_q.kind;
  assign start_offset_o = tok_q.off;
  assign token_length_o = tok_q.len;
  assign start_row_o    = tok_q.row;
  assign start_col_o    = tok_q.col;
  assign last_of_run_o  = last_q;

endmodule
`default_nettype wire

@@ rtl/source_byte_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_byte_tokenizer: streaming lexical tokenizer
// Groups source bytes into identifier, number, string, symbol, end and
// error tokens with start offset, length, row and column.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock while the queue has room and emits
// one token per clock while tokens are queued and the output is not stalled.
// The scanner classifies each byte in the cycle it is accepted and writes the
// up to three tokens that byte closes as one entry of a four-deep queue; the
// output stage drains that queue one token per beat through an output
// register, so the input holds its full rate as long as the token count stays
// at one per byte on average and the queue has room. A token passes through a
// queue entry and the output register before it reaches the output. The byte
// flagged end_of_source closes any open token, adds the end (or error) token,
// and returns the scanner to offset 0, row 1, column 1 for the next source.
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
  parameter int unsigned OFFSET_BITS   = stb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [7:0]             source_byte_i,
  input  wire logic                   end_of_source_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  token_kind_o,
  output logic [OFFSET_BITS-1:0]      start_offset_o,
  output logic [OFFSET_BITS-1:0]      token_length_o,
  output logic [POSITION_BITS-1:0]    start_row_o,
  output logic [POSITION_BITS-1:0]    start_col_o,
  output logic                        last_of_run_o
);

  localparam int unsigned BUNDLE_W = stb_pkg::bundle_bits(OFFSET_BITS, POSITION_BITS);

  logic                  push;
  logic [BUNDLE_W-1:0]   push_data;
  logic                  pop;
  logic [BUNDLE_W-1:0]   head_data;
  stb_pkg::fifo_status_t fifo_status;

  stb_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .fifo_status_i   (fifo_status),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  stb_fifo #(
    .DATA_W (BUNDLE_W),
    .DEPTH  (stb_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_data_o (head_data),
    .status_o    (fifo_status)
  );

  stb_back #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_data_i    (head_data),
    .fifo_status_i  (fifo_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .start_row_o    (start_row_o),
    .start_col_o    (start_col_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

@@ tb/token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: scoreboard of the source byte tokenizer
// Watches both channels, rebuilds the token stream from each accepted source
// byte with its own scanner, and compares every token beat with the oldest
// token it expects.
// ----------------------------------------------------------------------------
module token_checker #(
  parameter int unsigned OFFSET_BITS   = stb_pkg::OFFSET_BITS_DEF,
  parameter int unsigned POSITION_BITS = stb_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [7:0]               source_byte_i,
  input  logic                     end_of_source_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [2:0]               token_kind_i,
  input  logic [OFFSET_BITS-1:0]   start_offset_i,
  input  logic [OFFSET_BITS-1:0]   token_length_i,
  input  logic [POSITION_BITS-1:0] start_row_i,
  input  logic [POSITION_BITS-1:0] start_col_i,
  input  logic                     last_of_run_i,
  output int                       fails_o,
  output int                       pending_o,
  output int                       bytes_o,
  output int                       tokens_o,
  output logic [5:0]               kinds_o
);

  localparam logic [POSITION_BITS-1:0] POS_TOP = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [OFFSET_BITS-1:0]   OFF_ONE = OFFSET_BITS'(1);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_DOLLAR
  } scan_e;

  typedef struct {
    stb_pkg::kind_e           kind;
    logic [OFFSET_BITS-1:0]   offset;
    logic [OFFSET_BITS-1:0]   length;
    logic [POSITION_BITS-1:0] row;
    logic [POSITION_BITS-1:0] col;
    logic                     last;
  } token_t;

  token_t expected_tokens[$];

  scan_e                    mode;
  logic [OFFSET_BITS-1:0]   tok_off, cur_off;
  logic [POSITION_BITS-1:0] tok_row, tok_col, cur_row, cur_col;

  int         mismatches;
  int         bytes_seen;
  int         tokens_checked;
  logic [5:0] kinds_seen;

  function automatic logic word_first(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == stb_pkg::CH_UNDER;
  endfunction

  function automatic logic decimal(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic reset_scan();
    mode    = SCAN_IDLE;
    tok_off = '0;
    tok_row = POS_ONE;
    tok_col = POS_ONE;
    cur_off = '0;
    cur_row = POS_ONE;
    cur_col = POS_ONE;
  endtask

  task automatic add_token(input stb_pkg::kind_e kind, input logic [OFFSET_BITS-1:0] off,
                           input logic [OFFSET_BITS-1:0] len,
                           input logic [POSITION_BITS-1:0] row,
                           input logic [POSITION_BITS-1:0] col);
    token_t t;
    t.kind   = kind;
    t.offset = off;
    t.length = len;
    t.row    = row;
    t.col    = col;
    t.last   = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic open_token(input scan_e m);
    mode    = m;
    tok_off = cur_off;
    tok_row = cur_row;
    tok_col = cur_col;
  endtask

  // work out the tokens that one source byte closes
  task automatic tokenize_byte(input logic [7:0] b, input logic eos);
    logic taken;
    int   first;
    taken = 1'b0;
    first = expected_tokens.size();
    case (mode)
      SCAN_IDENT: begin
        if (word_first(b) || decimal(b)) taken = 1'b1;
        else begin
          add_token(stb_pkg::KIND_IDENT, tok_off, cur_off - tok_off, tok_row, tok_col);
          mode = SCAN_IDLE;
        end
      end
      SCAN_NUMBER: begin
        if (decimal(b)) taken = 1'b1;
        else begin
          add_token(stb_pkg::KIND_NUMBER, tok_off, cur_off - tok_off, tok_row, tok_col);
          mode = SCAN_IDLE;
        end
      end
      SCAN_STRING: begin
        taken = 1'b1;
        if (b == stb_pkg::CH_QUOTE) begin
          add_token(stb_pkg::KIND_STRING, tok_off, cur_off + OFF_ONE - tok_off,
                    tok_row, tok_col);
          mode = SCAN_IDLE;
        end
      end
      SCAN_DOLLAR: begin
        if (word_first(b)) begin
          mode  = SCAN_IDENT;
          taken = 1'b1;
        end else begin
          add_token(stb_pkg::KIND_SYMBOL, tok_off, OFF_ONE, tok_row, tok_col);
          mode = SCAN_IDLE;
        end
      end
      default: mode = SCAN_IDLE;
    endcase

    if (!taken && !(b == stb_pkg::CH_NL || b == stb_pkg::CH_SPACE ||
                    b == stb_pkg::CH_TAB || b == stb_pkg::CH_CR)) begin
      if (b == stb_pkg::CH_DOLLAR) open_token(SCAN_DOLLAR);
      else if (word_first(b)) open_token(SCAN_IDENT);
      else if (decimal(b)) open_token(SCAN_NUMBER);
      else if (b == stb_pkg::CH_QUOTE) open_token(SCAN_STRING);
      else add_token(stb_pkg::KIND_SYMBOL, cur_off, OFF_ONE, cur_row, cur_col);
    end

    cur_off = cur_off + 1'b1;
    if (b == stb_pkg::CH_NL) begin
      if (cur_row != POS_TOP) cur_row = cur_row + 1'b1;
      cur_col = POS_ONE;
    end else if (cur_col != POS_TOP) begin
      cur_col = cur_col + 1'b1;
    end

    if (eos) begin
      case (mode)
        SCAN_IDENT:
          add_token(stb_pkg::KIND_IDENT, tok_off, cur_off - tok_off, tok_row, tok_col);
        SCAN_NUMBER:
          add_token(stb_pkg::KIND_NUMBER, tok_off, cur_off - tok_off, tok_row, tok_col);
        SCAN_DOLLAR:
          add_token(stb_pkg::KIND_SYMBOL, tok_off, OFF_ONE, tok_row, tok_col);
        SCAN_STRING:
          add_token(stb_pkg::KIND_ERROR, tok_off, cur_off - tok_off, tok_row, tok_col);
        default: ;
      endcase
      if (mode != SCAN_STRING) add_token(stb_pkg::KIND_EOF, cur_off, '0, cur_row, cur_col);
      reset_scan();
    end

    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    mismatches++;
    $display("%0t mismatch on token %0d, %s: got %0d, expected %0d",
             $time, tokens_checked, what, got, want);
  endtask

  task automatic check_token();
    token_t want;
    tokens_checked++;
    if (expected_tokens.size() == 0) begin
      report("token with none expected, kind", token_kind_i, 0);
      return;
    end
    want = expected_tokens.pop_front();
    kinds_seen[want.kind] = 1'b1;
    if (token_kind_i !== want.kind) report("kind", token_kind_i, want.kind);
    if (start_offset_i !== want.offset) report("start offset", start_offset_i, want.offset);
    if (token_length_i !== want.length) report("length", token_length_i, want.length);
    if (start_row_i !== want.row) report("row", start_row_i, want.row);
    if (start_col_i !== want.col) report("column", start_col_i, want.col);
    if (last_of_run_i !== want.last) report("last of run", last_of_run_i, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      expected_tokens.delete();
      mismatches     = 0;
      bytes_seen     = 0;
      tokens_checked = 0;
      kinds_seen     = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        tokenize_byte(source_byte_i, end_of_source_i);
        bytes_seen++;
      end
      if (out_valid_i && !out_stall_i) check_token();
    end
    // publish at the edge so the stimulus side reads settled values
    fails_o   <= mismatches;
    pending_o <= expected_tokens.size();
    bytes_o   <= bytes_seen;
    tokens_o  <= tokens_checked;
    kinds_o   <= kinds_seen;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the source byte tokenizer
// Feeds hand-picked corner sources and random token-shaped sources with
// random idle and stall bursts; the token checker predicts and compares
// every token beat.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned OB             = stb_pkg::OFFSET_BITS_DEF;
  localparam int unsigned PB             = stb_pkg::POSITION_BITS_DEF;
  localparam int          RANDOM_BYTES   = 334;
  localparam int          QUIET_BYTES    = 70;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic          clk_i           = 1'b0;
  logic          rst_ni          = 1'b0;
  logic          in_valid_i      = 1'b0;
  logic [7:0]    source_byte_i   = '0;
  logic          end_of_source_i = 1'b0;
  logic          out_stall_i     = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  logic [2:0]    token_kind_o;
  logic [OB-1:0] start_offset_o;
  logic [OB-1:0] token_length_o;
  logic [PB-1:0] start_row_o;
  logic [PB-1:0] start_col_o;
  logic          last_of_run_o;

  int         fails, pending, bytes_seen, tokens_seen;
  logic [5:0] kinds_seen;

  bit         quiet = 1'b0;
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         sent = 0;
  int         sources = 0;
  logic [7:0] text_q[$];

  source_byte_tokenizer #(
    .OFFSET_BITS  (OB),
    .POSITION_BITS(PB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_byte_i  (source_byte_i),
    .end_of_source_i(end_of_source_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .start_row_o    (start_row_o),
    .start_col_o    (start_col_o),
    .last_of_run_o  (last_of_run_o)
  );

  token_checker #(
    .OFFSET_BITS  (OB),
    .POSITION_BITS(PB)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .source_byte_i  (source_byte_i),
    .end_of_source_i(end_of_source_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_i   (token_kind_o),
    .start_offset_i (start_offset_o),
    .token_length_i (token_length_o),
    .start_row_i    (start_row_o),
    .start_col_i    (start_col_o),
    .last_of_run_i  (last_of_run_o),
    .fails_o        (fails),
    .pending_o      (pending),
    .bytes_o        (bytes_seen),
    .tokens_o       (tokens_seen),
    .kinds_o        (kinds_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // token sink: stall in short random bursts
  always @(posedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles, %0d tokens outstanding",
               WATCHDOG_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] head_byte();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return stb_pkg::CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 2) == 0) return 8'("0" + $urandom_range(0, 9));
    return head_byte();
  endfunction

  // hold the beat until it is taken, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    source_byte_i   <= b;
    end_of_source_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (eos) sources++;
  endtask

  task automatic add_fragment();
    int len;
    logic [7:0] b;
    len = $urandom_range(1, 5);
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        text_q.push_back(head_byte());
        repeat (len - 1) text_q.push_back(tail_byte());
      end
      3, 4: repeat (len) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      5: begin
        text_q.push_back(stb_pkg::CH_DOLLAR);
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(head_byte());
          repeat (len - 1) text_q.push_back(tail_byte());
        end
      end
      6: begin
        text_q.push_back(stb_pkg::CH_QUOTE);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) b = stb_pkg::CH_NL;
          else do b = 8'($urandom_range(0, 255)); while (b == stb_pkg::CH_QUOTE);
          text_q.push_back(b);
        end
        // leave some strings open
        if ($urandom_range(0, 5) != 0) text_q.push_back(stb_pkg::CH_QUOTE);
      end
      7, 8: repeat (len) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(stb_pkg::CH_SPACE);
          1:       text_q.push_back(stb_pkg::CH_TAB);
          2:       text_q.push_back(stb_pkg::CH_CR);
          default: text_q.push_back(stb_pkg::CH_NL);
        endcase
      end
      9, 10: text_q.push_back(8'($urandom_range(33, 47)));
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_source(input int frags);
    text_q.delete();
    repeat (frags) add_fragment();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a dollar identifier and a lone dollar, a number, multi-line string, high and control bytes,
    // three tokens from the final byte
    send_byte(stb_pkg::CH_DOLLAR, 1'b0);
    send_byte("_", 1'b0);
    send_byte("Z", 1'b0);
    send_byte("9", 1'b0);
    send_byte(stb_pkg::CH_DOLLAR, 1'b0);
    send_byte("0", 1'b0);
    send_byte(stb_pkg::CH_TAB, 1'b0);
    send_byte(stb_pkg::CH_QUOTE, 1'b0);
    send_byte(stb_pkg::CH_NL, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(stb_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(stb_pkg::CH_CR, 1'b0);
    send_byte("z", 1'b0);
    send_byte("+", 1'b1);
    // lone dollar at the end, open string at the end, one-byte sources
    send_byte(stb_pkg::CH_DOLLAR, 1'b1);
    send_byte(stb_pkg::CH_QUOTE, 1'b0);
    send_byte("a", 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte("5", 1'b1);
    send_byte(stb_pkg::CH_QUOTE, 1'b0);
    send_byte(stb_pkg::CH_QUOTE, 1'b1);
    send_byte(stb_pkg::CH_SPACE, 1'b1);
    send_byte(stb_pkg::CH_DOLLAR, 1'b0);
    send_byte("+", 1'b1);
    drain();

    base = sent;
    while (sent < base + RANDOM_BYTES) begin
      if (sent >= base + RANDOM_BYTES - QUIET_BYTES) quiet = 1'b1;
      send_source($urandom_range(1, 10));
    end
    quiet = 1'b1;
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d sources, %0d bytes and %0d tokens (kinds seen %b),",
             sources, bytes_seen, tokens_seen, kinds_seen);
    $display("with dollar identifiers, multi-line and open strings and a full drain.");
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/stb_pkg.sv
rtl/stb_front.sv
rtl/stb_fifo.sv
rtl/stb_back.sv
rtl/source_byte_tokenizer.sv
tb/token_checker.sv
tb/tb.sv
